// File: sv/dtf_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the body character class for the delimited token finder.
// No dependencies; every other file takes its names from here by scope.
package dtf_pkg;

    localparam int unsigned MAX_LEN = 65535;
    localparam int unsigned POS_W   = $clog2(MAX_LEN + 2);
    localparam int unsigned OFS_W   = 16;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned MIN_LEN = 4;

    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_LEN);
    localparam logic [POS_W-1:0] POS_SAT   = POS_W'(MAX_LEN + 1);
    localparam logic [POS_W-1:0] POS_MIN   = POS_W'(MIN_LEN);

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE = 1'b1;

    localparam logic [BYTE_W-1:0] OPEN_RST  = 8'h7B;
    localparam logic [BYTE_W-1:0] CLOSE_RST = 8'h7D;

    // Character codes
    localparam logic [BYTE_W-1:0] CH_NUL        = 8'h00;
    localparam logic [BYTE_W-1:0] CH_DOLLAR     = 8'h24;
    localparam logic [BYTE_W-1:0] CH_EQUAL      = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [BYTE_W-1:0] CH_DASH       = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_SLASH      = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_TIMES      = 8'hD7;
    localparam logic [BYTE_W-1:0] CH_DIVIDE     = 8'hF7;

    typedef enum logic [1:0] {
        SCAN_SEARCH,
        SCAN_DOLLAR,
        SCAN_PRE,
        SCAN_POST
    } t_scan_mode;

    typedef struct packed {
        logic [BYTE_W-1:0] open_char;
        logic [BYTE_W-1:0] close_char;
    } t_cfg;

    typedef struct packed {
        logic             found;
        logic [OFS_W-1:0] body_offset;
        logic [OFS_W-1:0] body_length;
        logic             too_long;
    } t_result;

    // Latin-1 alphanumerics plus the few punctuation bytes a body may hold before '='
    function automatic logic body_char_ok(input logic [BYTE_W-1:0] c);
        logic ok;
        ok = (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A], [8'hC0:8'hFF]})
             && (c != CH_TIMES) && (c != CH_DIVIDE);
        return ok || (c == CH_UNDERSCORE) || (c == CH_DASH) || (c == CH_SLASH)
               || (c == CH_EQUAL);
    endfunction

endpackage

// File: sv/dtf_text_if.sv
`timescale 1ns / 1ps
// Input channel of the token finder: one text byte per transfer with a last marker.
// Depends on dtf_pkg for field widths.
interface dtf_text_if;
    logic                       valid;
    logic                       ready;
    logic [dtf_pkg::BYTE_W-1:0] text_byte;
    logic                       is_last;

    modport source (output valid, text_byte, is_last, input ready);
    modport sink   (input valid, text_byte, is_last, output ready);
endinterface

// File: sv/dtf_result_if.sv
`timescale 1ns / 1ps
// Result channel of the token finder: one result per string.
// Depends on dtf_pkg for field widths.
interface dtf_result_if;
    logic                      valid;
    logic                      ready;
    logic                      found;
    logic [dtf_pkg::OFS_W-1:0] body_offset;
    logic [dtf_pkg::OFS_W-1:0] body_length;
    logic                      too_long;

    modport source (output valid, found, body_offset, body_length, too_long, input ready);
    modport sink   (input valid, found, body_offset, body_length, too_long, output ready);
endinterface

// File: sv/delimited_token_finder_core.sv
`timescale 1ns / 1ps
// Top level of the delimited token finder: input register, scanner, result register.
// Depends on dtf_pkg, dtf_text_if, dtf_result_if, dtf_cfg_regs and dtf_scanner.
//
//   channel   direction  transfer                 payload
//   i_text    in         valid & ready            text_byte, is_last
//   o_res     out        valid & ready            found, body_offset, body_length, too_long
//   cfg       in         i_cfg_we (no handshake)  i_cfg_index, i_cfg_data
//
// One byte per cycle sustained while no last byte waits; a byte is scanned while it sits
// in the input register, and a result is loaded as its last byte leaves that register.
// Synchronous active-low reset clears the scan state and both valid flags and
// loads the default delimiters. A pending result is held while o_res.ready is low;
// non-last bytes keep flowing, and a last byte waits only while a result is pending
// and o_res.ready is low.
module delimited_token_finder_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    dtf_text_if.sink                      i_text,
    dtf_result_if.source                  o_res,
    input  logic                          i_cfg_we,
    input  logic [dtf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dtf_pkg::BYTE_W-1:0]    i_cfg_data
);

    dtf_pkg::t_cfg              w_cfg;
    dtf_pkg::t_result           w_result;
    logic                       w_adv;

    logic                       r_in_valid;
    logic [dtf_pkg::BYTE_W-1:0] r_in_byte;
    logic                       r_in_last;
    logic                       r_out_valid;
    dtf_pkg::t_result           r_out;

    dtf_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Advance the held byte unless it ends a string, the result slot is full and o_res.ready is low
    assign w_adv        = r_in_valid && (!r_in_last || !r_out_valid || o_res.ready);
    assign i_text.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_text.ready) begin
            r_in_valid <= i_text.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_text.ready && i_text.valid) begin
            r_in_byte <= i_text.text_byte;
            r_in_last <= i_text.is_last;
        end
    end

    dtf_scanner u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_adv    (w_adv),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_last) begin
            r_out <= w_result;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.found       = r_out.found;
    assign o_res.body_offset = r_out.body_offset;
    assign o_res.body_length = r_out.body_length;
    assign o_res.too_long    = r_out.too_long;

endmodule

// File: sv/dtf_cfg_regs.sv
`timescale 1ns / 1ps
// Open and close delimiter registers behind the plain write port.
// Depends on dtf_pkg.
module dtf_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dtf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dtf_pkg::BYTE_W-1:0]    i_cfg_data,
    output dtf_pkg::t_cfg                 o_cfg
);

    dtf_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.open_char  <= dtf_pkg::OPEN_RST;
            r_cfg.close_char <= dtf_pkg::CLOSE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dtf_pkg::CFG_OPEN:  r_cfg.open_char  <= i_cfg_data;
                dtf_pkg::CFG_CLOSE: r_cfg.close_char <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: sv/dtf_scanner.sv
`timescale 1ns / 1ps
// Per-string scan state: mode, byte counter, candidate start and the first match.
// Depends on dtf_pkg; updated once for every byte that leaves the input register.
module dtf_scanner (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  dtf_pkg::t_cfg              i_cfg,
    input  logic                       i_adv,
    input  logic [dtf_pkg::BYTE_W-1:0] i_byte,
    input  logic                       i_last,
    output dtf_pkg::t_result           o_result
);

    dtf_pkg::t_scan_mode        r_mode, n_mode;
    logic [dtf_pkg::POS_W-1:0]  r_pos, n_pos;
    logic [dtf_pkg::OFS_W-1:0]  r_cand, n_cand;
    logic                       r_found, n_found;
    logic [dtf_pkg::OFS_W-1:0]  r_off, n_off;
    logic [dtf_pkg::OFS_W-1:0]  r_len, n_len;
    logic                       r_ended, n_ended;

    logic                       w_counting;
    logic [dtf_pkg::OFS_W-1:0]  w_pos16;

    assign w_counting = (r_pos < dtf_pkg::POS_LIMIT);
    assign w_pos16    = r_pos[dtf_pkg::OFS_W-1:0];

    // Next state
    always_comb begin
        n_mode  = r_mode;
        n_cand  = r_cand;
        n_found = r_found;
        n_off   = r_off;
        n_len   = r_len;
        n_ended = r_ended;
        n_pos   = w_counting ? r_pos + 1'b1 : dtf_pkg::POS_SAT;
        if (w_counting && !r_ended && !r_found) begin
            if (i_byte == dtf_pkg::CH_NUL) begin
                n_ended = 1'b1;
            end else begin
                case (r_mode)
                    dtf_pkg::SCAN_SEARCH: begin
                        if (i_byte == dtf_pkg::CH_DOLLAR) n_mode = dtf_pkg::SCAN_DOLLAR;
                    end
                    dtf_pkg::SCAN_DOLLAR: begin
                        if (i_byte == i_cfg.open_char) begin
                            n_mode = dtf_pkg::SCAN_PRE;
                            n_cand = w_pos16 + 1'b1;
                        end else if (i_byte != dtf_pkg::CH_DOLLAR) begin
                            n_mode = dtf_pkg::SCAN_SEARCH;
                        end
                    end
                    dtf_pkg::SCAN_PRE, dtf_pkg::SCAN_POST: begin
                        if (i_byte == i_cfg.close_char) begin
                            n_found = 1'b1;
                            n_off   = r_cand;
                            n_len   = w_pos16 - r_cand;
                        end else if (r_mode == dtf_pkg::SCAN_PRE) begin
                            if (i_byte == dtf_pkg::CH_EQUAL) begin
                                n_mode = dtf_pkg::SCAN_POST;
                            end else if (!dtf_pkg::body_char_ok(i_byte)) begin
                                if (i_byte == dtf_pkg::CH_DOLLAR) begin
                                    // '$' as open char: a '$' right after it opens anew
                                    if (w_pos16 == r_cand
                                        && i_cfg.open_char == dtf_pkg::CH_DOLLAR) begin
                                        n_cand = w_pos16 + 1'b1;
                                    end else begin
                                        n_mode = dtf_pkg::SCAN_DOLLAR;
                                    end
                                end else begin
                                    n_mode = dtf_pkg::SCAN_SEARCH;
                                end
                            end
                        end
                    end
                    default: n_mode = dtf_pkg::SCAN_SEARCH;
                endcase
            end
        end
    end

    // Result for a string that ends on this byte
    always_comb begin
        o_result.found       = n_found && (n_pos >= dtf_pkg::POS_MIN);
        o_result.body_offset = o_result.found ? n_off : '0;
        o_result.body_length = o_result.found ? n_len : '0;
        o_result.too_long    = (n_pos > dtf_pkg::POS_LIMIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_adv && i_last)) begin
            r_mode  <= dtf_pkg::SCAN_SEARCH;
            r_pos   <= '0;
            r_cand  <= '0;
            r_found <= 1'b0;
            r_off   <= '0;
            r_len   <= '0;
            r_ended <= 1'b0;
        end else if (i_adv) begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_cand  <= n_cand;
            r_found <= n_found;
            r_off   <= n_off;
            r_len   <= n_len;
            r_ended <= n_ended;
        end
    end

endmodule

// File: sv/dtf_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the token finder, attached to the top level by bind.
// Depends on dtf_pkg for field widths.
module dtf_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic                      i_found,
    input logic [dtf_pkg::OFS_W-1:0] i_body_offset,
    input logic [dtf_pkg::OFS_W-1:0] i_body_length
);

    // A pending result stays up until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before transfer");

    // No result straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A miss reports zero offset and length
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_found |-> (i_body_offset == '0) && (i_body_length == '0))
        else $error("nonzero offset or length without a match");

    // A body starts after at least the dollar and the open delimiter
    a_offset_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_found |-> (i_body_offset >= dtf_pkg::OFS_W'(2)))
        else $error("match offset too small");

endmodule

bind delimited_token_finder_core dtf_checker u_dtf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_found       (o_res.found),
    .i_body_offset (o_res.body_offset),
    .i_body_length (o_res.body_length)
);

// File: dv/tb_delimited_token_finder_core.sv
`timescale 1ns / 1ps
// Testbench for delimited_token_finder_core: a short directed table, random strings
// over several delimiter settings, then a stretch with no idling; checked by a predictor.
// Depends on dtf_pkg, dtf_text_if, dtf_result_if and the core.
module tb_delimited_token_finder_core;

    typedef struct packed {
        logic [dtf_pkg::BYTE_W-1:0] open_c;
        logic [dtf_pkg::BYTE_W-1:0] close_c;
        logic [3:0]                 n_bytes;
        logic [79:0]                text;      // left-aligned, first byte in the top bits
        logic                       typed;
        dtf_pkg::t_result           want;
    } t_row;

    localparam int N_ROWS = 6;
    localparam t_row DIRECTED_ROWS [N_ROWS] = '{
        // shortest candidate, too short to count
        '{dtf_pkg::OPEN_RST, dtf_pkg::CLOSE_RST, 4'd3, {"${}", 56'h0}, 1'b1,
          '{1'b0, 16'd0, 16'd0, 1'b0}},
        '{dtf_pkg::OPEN_RST, dtf_pkg::CLOSE_RST, 4'd4, {"${a}", 48'h0}, 1'b1,
          '{1'b1, 16'd2, 16'd1, 1'b0}},
        // NUL inside the body ends the text
        '{dtf_pkg::OPEN_RST, dtf_pkg::CLOSE_RST, 4'd4, {"${", 8'h00, "}", 48'h0}, 1'b1,
          '{1'b0, 16'd0, 16'd0, 1'b0}},
        // '$' fails a body and restarts; Latin-1 letter, then '=' lets 0xF7 through
        '{dtf_pkg::OPEN_RST, dtf_pkg::CLOSE_RST, 4'd9,
          {"${a${", 8'hC0, "=", 8'hF7, "}", 8'h0}, 1'b0, '0},
        // open char equal to '$'
        '{dtf_pkg::CH_DOLLAR, dtf_pkg::CLOSE_RST, 4'd4, {"$$$}", 48'h0}, 1'b0, '0},
        // NUL as close char never matches
        '{8'hFF, dtf_pkg::CH_NUL, 4'd4, {"$", 8'hFF, "a", 8'h00, 48'h0}, 1'b1,
          '{1'b0, 16'd0, 16'd0, 1'b0}}
    };

    localparam int N_PHASES = 8;
    localparam logic [dtf_pkg::BYTE_W-1:0] PHASE_OPEN  [N_PHASES] =
        '{dtf_pkg::OPEN_RST, 8'h28, dtf_pkg::CH_DOLLAR, 8'h7C, 8'hFF, dtf_pkg::CH_NUL,
          8'h41, dtf_pkg::OPEN_RST};
    localparam logic [dtf_pkg::BYTE_W-1:0] PHASE_CLOSE [N_PHASES] =
        '{dtf_pkg::CLOSE_RST, 8'h29, dtf_pkg::CH_DOLLAR, 8'h7C, 8'h80, 8'hFF,
          dtf_pkg::CH_NUL, dtf_pkg::CLOSE_RST};
    localparam int PHASE_BYTES = 90;
    localparam int CALM_BYTES  = 40;

    logic i_clk;
    logic i_rst_n;
    logic                          cfg_we;
    logic [dtf_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [dtf_pkg::BYTE_W-1:0]    cfg_data;

    dtf_text_if   text_ch ();
    dtf_result_if res_ch ();

    delimited_token_finder_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_text      (text_ch),
        .o_res       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // predictor state
    logic [dtf_pkg::BYTE_W-1:0] fnd_open;
    logic [dtf_pkg::BYTE_W-1:0] fnd_close;
    dtf_pkg::t_scan_mode        fnd_mode;
    int unsigned                fnd_pos;
    int unsigned                fnd_start;
    logic                       fnd_hit;
    int unsigned                fnd_off;
    int unsigned                fnd_len;
    logic                       fnd_ended;
    logic                       fnd_use_typed;
    dtf_pkg::t_result           fnd_typed;

    dtf_pkg::t_result           pending_tokens [$];
    logic [dtf_pkg::BYTE_W-1:0] text_bytes [$];

    int  errors;
    int  bytes_sent;
    int  strings_sent;
    int  settings_used;
    int  results_seen;
    int  found_seen;
    int  too_long_seen;
    bit  stalls_on;
    int  rx_hold;
    bit  rx_calm;

    always #10 i_clk = ~i_clk;

    function automatic logic body_byte_ok(input logic [dtf_pkg::BYTE_W-1:0] c);
        logic letter;
        letter = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A)
                 || (c >= 8'h61 && c <= 8'h7A) || (c >= 8'hC0);
        if (c == dtf_pkg::CH_TIMES || c == dtf_pkg::CH_DIVIDE) begin
            return 1'b0;
        end
        return letter || c == dtf_pkg::CH_UNDERSCORE || c == dtf_pkg::CH_DASH
               || c == dtf_pkg::CH_SLASH || c == dtf_pkg::CH_EQUAL;
    endfunction

    function automatic void clear_finder();
        fnd_mode  = dtf_pkg::SCAN_SEARCH;
        fnd_pos   = 0;
        fnd_start = 0;
        fnd_hit   = 1'b0;
        fnd_off   = 0;
        fnd_len   = 0;
        fnd_ended = 1'b0;
    endfunction

    function automatic void scan_token_byte(input logic [dtf_pkg::BYTE_W-1:0] c,
                                            input int unsigned pos);
        if (fnd_ended || fnd_hit) begin
            return;
        end
        if (c == dtf_pkg::CH_NUL) begin
            fnd_ended = 1'b1;
            return;
        end
        case (fnd_mode)
            dtf_pkg::SCAN_SEARCH: begin
                if (c == dtf_pkg::CH_DOLLAR) fnd_mode = dtf_pkg::SCAN_DOLLAR;
            end
            dtf_pkg::SCAN_DOLLAR: begin
                if (c == fnd_open) begin
                    fnd_mode  = dtf_pkg::SCAN_PRE;
                    fnd_start = pos + 1;
                end else if (c != dtf_pkg::CH_DOLLAR) begin
                    fnd_mode = dtf_pkg::SCAN_SEARCH;
                end
            end
            default: begin
                if (c == fnd_close) begin
                    fnd_hit = 1'b1;
                    fnd_off = fnd_start;
                    fnd_len = pos - fnd_start;
                end else if (fnd_mode == dtf_pkg::SCAN_PRE) begin
                    if (c == dtf_pkg::CH_EQUAL) begin
                        fnd_mode = dtf_pkg::SCAN_POST;
                    end else if (!body_byte_ok(c)) begin
                        if (c != dtf_pkg::CH_DOLLAR) begin
                            fnd_mode = dtf_pkg::SCAN_SEARCH;
                        end else if (pos == fnd_start && fnd_open == dtf_pkg::CH_DOLLAR) begin
                            // "$$$": the failing '$' is itself the open char
                            fnd_start = pos + 1;
                        end else begin
                            fnd_mode = dtf_pkg::SCAN_DOLLAR;
                        end
                    end
                end
            end
        endcase
    endfunction

    function automatic void track_token_byte(input logic [dtf_pkg::BYTE_W-1:0] c,
                                             input logic last);
        int unsigned      counted;
        dtf_pkg::t_result r;
        if (fnd_pos < dtf_pkg::MAX_LEN) begin
            scan_token_byte(c, fnd_pos);
            fnd_pos++;
        end else begin
            fnd_pos = dtf_pkg::MAX_LEN + 1;
        end
        if (!last) begin
            return;
        end
        counted       = (fnd_pos > dtf_pkg::MAX_LEN) ? dtf_pkg::MAX_LEN : fnd_pos;
        r.found       = fnd_hit && counted >= dtf_pkg::MIN_LEN;
        r.body_offset = r.found ? fnd_off[dtf_pkg::OFS_W-1:0] : '0;
        r.body_length = r.found ? fnd_len[dtf_pkg::OFS_W-1:0] : '0;
        r.too_long    = fnd_pos > dtf_pkg::MAX_LEN;
        pending_tokens.push_back(fnd_use_typed ? fnd_typed : r);
        clear_finder();
    endfunction

    function automatic void note_mismatch(input string what, input dtf_pkg::t_result want,
                                          input dtf_pkg::t_result got);
        errors++;
        if (errors <= 10) begin
            $display("%0t mismatch %s: expected found=%0d off=%0d len=%0d too_long=%0d,",
                     $realtime, what, want.found, want.body_offset, want.body_length,
                     want.too_long);
            $display("    got found=%0d off=%0d len=%0d too_long=%0d",
                     got.found, got.body_offset, got.body_length, got.too_long);
        end
    endfunction

    function automatic logic [dtf_pkg::BYTE_W-1:0] pick_body_byte();
        case ($urandom_range(0, 5))
            0: return 8'h30 + 8'($urandom_range(0, 9));
            1: return 8'h41 + 8'($urandom_range(0, 25));
            2: return 8'hC0 + 8'($urandom_range(0, 63));
            3: begin
                case ($urandom_range(0, 2))
                    0: return dtf_pkg::CH_UNDERSCORE;
                    1: return dtf_pkg::CH_DASH;
                    default: return dtf_pkg::CH_SLASH;
                endcase
            end
            default: return 8'h61 + 8'($urandom_range(0, 25));
        endcase
    endfunction

    function automatic logic [dtf_pkg::BYTE_W-1:0] pick_noise_byte();
        case ($urandom_range(0, 7))
            0: return dtf_pkg::CH_DOLLAR;
            1: return fnd_open;
            2: return fnd_close;
            3: return dtf_pkg::CH_EQUAL;
            4: return pick_body_byte();
            5: return ($urandom_range(0, 3) == 0) ? dtf_pkg::CH_NUL
                                                   : 8'($urandom_range(1, 255));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly well-formed references with random bodies, some corrupted; the rest noise.
    function automatic void build_random_string();
        int          seg_at;
        logic [7:0]  b;
        text_bytes.delete();
        if ($urandom_range(0, 9) < 7) begin
            repeat ($urandom_range(0, 3)) begin
                text_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
            end
            repeat ($urandom_range(1, 2)) begin
                seg_at = text_bytes.size();
                text_bytes.push_back(dtf_pkg::CH_DOLLAR);
                if ($urandom_range(0, 5) == 0) text_bytes.push_back(dtf_pkg::CH_DOLLAR);
                text_bytes.push_back(fnd_open);
                repeat ($urandom_range(0, 5)) text_bytes.push_back(pick_body_byte());
                if ($urandom_range(0, 1) == 1) begin
                    text_bytes.push_back(dtf_pkg::CH_EQUAL);
                    repeat ($urandom_range(0, 3)) begin
                        b = 8'($urandom_range(1, 255));
                        text_bytes.push_back(b == fnd_close ? dtf_pkg::CH_EQUAL : b);
                    end
                end
                text_bytes.push_back(fnd_close);
                if ($urandom_range(0, 3) == 0) begin
                    text_bytes[$urandom_range(seg_at, text_bytes.size() - 1)] =
                        pick_noise_byte();
                end
            end
            repeat ($urandom_range(0, 3)) text_bytes.push_back(pick_noise_byte());
        end else begin
            repeat ($urandom_range(1, 12)) text_bytes.push_back(pick_noise_byte());
        end
    endfunction

    task automatic push_byte(input logic [dtf_pkg::BYTE_W-1:0] b, input logic last,
                             input bit gappy);
        if (gappy && $urandom_range(0, 3) == 0) begin
            text_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        text_ch.valid     <= 1'b1;
        text_ch.text_byte <= b;
        text_ch.is_last   <= last;
        do @(posedge i_clk); while (!text_ch.ready);
        track_token_byte(b, last);
        bytes_sent++;
        if (last) strings_sent++;
    endtask

    task automatic send_text(input bit gappy);
        foreach (text_bytes[i]) begin
            push_byte(text_bytes[i], i == text_bytes.size() - 1, gappy);
        end
    endtask

    // Drop valid and let the last result and the pipeline settle.
    task automatic wait_drained();
        text_ch.valid <= 1'b0;
        while (pending_tokens.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_delims(input logic [dtf_pkg::BYTE_W-1:0] open_c,
                                input logic [dtf_pkg::BYTE_W-1:0] close_c);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= dtf_pkg::CFG_OPEN;
        cfg_data  <= open_c;
        @(posedge i_clk);
        cfg_index <= dtf_pkg::CFG_CLOSE;
        cfg_data  <= close_c;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        fnd_open  = open_c;
        fnd_close = close_c;
        settings_used++;
    endtask

    // Filler string with a reference whose close char is the final byte.
    task automatic send_filler_string(input int unsigned n_bytes);
        int unsigned ref_at;
        logic [7:0]  b;
        ref_at = n_bytes - 5;
        for (int unsigned i = 0; i < n_bytes; i++) begin
            if (i == ref_at) b = dtf_pkg::CH_DOLLAR;
            else if (i == ref_at + 1) b = fnd_open;
            else if (i == ref_at + 4) b = fnd_close;
            else b = 8'h61 + 8'(i % 26);
            push_byte(b, i == n_bytes - 1, 1'b0);
        end
    endtask

    // Result side: random stall bursts, with calm stretches.
    always @(posedge i_clk) begin
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        if (stalls_on && !rx_calm && rx_hold == 0 && $urandom_range(0, 3) == 0) begin
            rx_hold = $urandom_range(1, 3);
        end
        if (rx_hold > 0) begin
            res_ch.ready <= 1'b0;
            rx_hold--;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        dtf_pkg::t_result got;
        dtf_pkg::t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = '{res_ch.found, res_ch.body_offset, res_ch.body_length, res_ch.too_long};
            results_seen++;
            if (got.found === 1'b1) found_seen++;
            if (got.too_long === 1'b1) too_long_seen++;
            if (pending_tokens.size() == 0) begin
                note_mismatch("with no result pending", '0, got);
            end else begin
                want = pending_tokens.pop_front();
                if (got.found !== want.found || got.body_offset !== want.body_offset
                    || got.body_length !== want.body_length
                    || got.too_long !== want.too_long) begin
                    note_mismatch("in result", want, got);
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("tb_delimited_token_finder_core: done, errors");
        $finish;
    end

    initial begin
        int   n;
        t_row row;
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = dtf_pkg::CFG_OPEN;
        cfg_data          = '0;
        text_ch.valid     = 1'b0;
        text_ch.text_byte = '0;
        text_ch.is_last   = 1'b0;
        res_ch.ready      = 1'b1;
        rx_hold           = 0;
        rx_calm           = 1'b0;
        stalls_on         = 1'b1;
        fnd_open          = dtf_pkg::OPEN_RST;
        fnd_close         = dtf_pkg::CLOSE_RST;
        fnd_use_typed     = 1'b0;
        fnd_typed         = '0;
        clear_finder();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        settings_used = 1;

        for (int r = 0; r < N_ROWS; r++) begin
            row = DIRECTED_ROWS[r];
            if (row.open_c != fnd_open || row.close_c != fnd_close) begin
                write_delims(row.open_c, row.close_c);
            end
            text_bytes.delete();
            for (int i = 0; i < row.n_bytes; i++) text_bytes.push_back(row.text[79 - 8 * i -: 8]);
            fnd_use_typed = row.typed;
            fnd_typed     = row.want;
            send_text(1'b1);
            fnd_use_typed = 1'b0;
        end

        for (int p = 0; p < N_PHASES; p++) begin
            write_delims(PHASE_OPEN[p], PHASE_CLOSE[p]);
            n = bytes_sent + PHASE_BYTES;
            while (bytes_sent < n) begin
                build_random_string();
                send_text($urandom_range(0, 2) != 0);
            end
        end

        // last part: no idling on either side
        wait_drained();
        stalls_on = 1'b0;
        n = bytes_sent + CALM_BYTES;
        while (bytes_sent < n) begin
            build_random_string();
            send_text(1'b0);
        end
        send_filler_string(24);
        send_filler_string(5);

        text_ch.valid <= 1'b0;
        for (int k = 0; k < 5000 && pending_tokens.size() != 0; k++) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (pending_tokens.size() != 0) begin
            errors += pending_tokens.size();
            $display("%0d expected results never arrived", pending_tokens.size());
        end
        $display("summary: %0d bytes in %0d strings over %0d delimiter settings",
                 bytes_sent, strings_sent, settings_used);
        $display("summary: %0d results checked, %0d with a reference, %0d too long, %0d mismatches",
                 results_seen, found_seen, too_long_seen, errors);
        if (errors == 0) begin
            $display("tb_delimited_token_finder_core: done, clean");
        end else begin
            $display("tb_delimited_token_finder_core: done, errors");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/dtf_pkg.sv
sv/dtf_text_if.sv
sv/dtf_result_if.sv
sv/dtf_cfg_regs.sv
sv/dtf_scanner.sv
sv/delimited_token_finder_core.sv
sv/dtf_checker.sv
dv/tb_delimited_token_finder_core.sv
